>>> src/nne_pkg.sv
`default_nettype none
package nne_pkg;

   localparam int WORD_BITS = 64;
   localparam int NNE_MAX_POINTS = 64;
   localparam int NNE_COEFF_BITS = 64;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [WORD_BITS-1:0] word_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODULUS      = 3'd0,
      CSR_ROOT         = 3'd1,
      CSR_ROOT_INVERSE = 3'd2,
      CSR_SIZE_INVERSE = 3'd3,
      CSR_DIRECTION    = 3'd4,
      CSR_LOG_SIZE     = 3'd5
   } csr_index_type;

   // (u + v) mod q for u, v below q, without overflow
   function automatic word_type add_mod(word_type u, word_type v, word_type q);
      word_type gap;
      gap = q - v;
      return (u >= gap) ? (u - gap) : (u + v);
   endfunction

   // (u - v) mod q for u, v below q
   function automatic word_type sub_mod(word_type u, word_type v, word_type q);
      return (u < v) ? (q - (v - u)) : (u - v);
   endfunction

endpackage
`default_nettype wire

>>> src/nne_if.sv
`default_nettype none
interface nne_req_if;
   import nne_pkg::*;
   logic valid;
   logic ready;
   word_type coefficient;
   modport source (output valid, output coefficient, input ready);
   modport sink (input valid, input coefficient, output ready);
endinterface

interface nne_rsp_if;
   import nne_pkg::*;
   logic valid;
   logic ready;
   word_type value;
   logic last;
   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

>>> src/negacyclic_ntt_engine.sv
`default_nettype none
// Negacyclic NTT engine.
// Write modulus, roots, size inverse, direction and log_size through the csr
// port while the block is idle; writing log_size restarts the current load.
// Coefficients enter on req_ch one at a time in index order; each is reduced
// modulo q and stored. After the n-th one the block reduces the store again;
// for n above one it builds the power table, runs the forward (pre-twist,
// DIF) or inverse (DIT, scaling) transform. Then it returns n values on rsp_ch
// in array order, last set on the final one.
// Every modular multiply and reduction runs on a bit-serial unit, so a
// transform of n points costs roughly 3n + n/2*log2 n such operations (n more
// multiplies in inverse mode); these units bound the speed of the block.
// req_ch is ready only while the block waits for a coefficient. Results wait
// in an output register while rsp_ch is stalled; nothing is dropped.
// Reset restores the register defaults (q = 3, n = 64, forward) and empties
// the load; store contents are left as they were.
module negacyclic_ntt_engine
   import nne_pkg::*;
#(
   parameter int MAX_POINTS = NNE_MAX_POINTS,
   parameter int COEFF_BITS = NNE_COEFF_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   nne_req_if.sink                        req_ch,
   nne_rsp_if.source                      rsp_ch,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire word_type                  csr_write_data
);

   localparam int AW = $clog2(MAX_POINTS + 1) - 1;
   localparam int DEPTH = 1 << AW;
   localparam int LW = $clog2(AW + 1);
   localparam word_type CMASK = {WORD_BITS{1'b1}} >> (WORD_BITS - COEFF_BITS);

   typedef enum logic [4:0] {
      ST_IDLE, ST_LD_RED, ST_RR_RD, ST_RR_GO, ST_RR_RUN, ST_PW_WR, ST_PW_MUL,
      ST_TW_RD, ST_TW_GO, ST_TW_RUN, ST_BF_RD, ST_BF_GO, ST_BF_RUN, ST_BF_WR2,
      ST_SC_RD, ST_SC_GO, ST_SC_MUL1, ST_SC_MUL2, ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
   } state_type;

   // configuration registers
   word_type modulus_ff, root_ff, root_inv_ff, size_inv_ff;
   logic direction_ff;
   logic [2:0] log_size_ff;

   state_type state_ff;
   logic [AW:0] load_count_ff;
   logic [AW-1:0] idx_ff;
   logic [LW-1:0] stage_ff;
   word_type x_ff, u_ff, v_ff, w_ff, res_ff;
   word_type rsp_value_ff;
   logic rsp_last_ff, rsp_valid_ff;

   // memories
   word_type coef_mem [DEPTH];
   word_type power_mem [DEPTH];
   word_type coef_rda_ff, coef_rdb_ff, power_rd_ff;
   logic coef_we, power_we;
   logic [AW-1:0] coef_waddr, coef_raddr_a, coef_raddr_b, power_raddr;
   word_type coef_wdata;

   // arithmetic units
   logic mul_start, mul_done, red_start, red_done;
   word_type mul_a, mul_b, mul_res, red_x, red_res;

   word_type q;
   logic [LW-1:0] log_eff;
   logic [AW-1:0] last_idx, half_last, lo_mask, k_lo, k_hi, w_idx;

   // effective modulus and length
   always_comb begin
      q = (modulus_ff < word_type'(2)) ? word_type'(2) : modulus_ff;
      log_eff = ({{LW{1'b0}}, log_size_ff} > (LW + 3)'(AW)) ? LW'(AW) : LW'(log_size_ff);
      last_idx = ~({AW{1'b1}} << log_eff);
      half_last = last_idx >> 1;
      lo_mask = ~({AW{1'b1}} << stage_ff);
      k_lo = ((idx_ff & ~lo_mask) << 1) | (idx_ff & lo_mask);
      k_hi = k_lo | (AW'(1) << stage_ff);
      w_idx = (idx_ff & lo_mask) << (log_eff - stage_ff);
   end

   nne_mulmod u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .q(q), .done(mul_done), .result(mul_res)
   );

   nne_reduce u_red (
      .clock(clock), .reset(reset), .start(red_start), .x(red_x), .q(q),
      .done(red_done), .result(red_res)
   );

   // memory addressing and write selection
   always_comb begin
      coef_raddr_a = idx_ff;
      coef_raddr_b = k_hi;
      power_raddr = idx_ff;
      if (state_ff == ST_BF_RD || state_ff == ST_BF_GO || state_ff == ST_BF_RUN ||
          state_ff == ST_BF_WR2) begin
         coef_raddr_a = k_lo;
         power_raddr = w_idx;
      end
      coef_we = 1'b0;
      coef_waddr = idx_ff;
      coef_wdata = mul_res;
      power_we = (state_ff == ST_PW_WR);
      red_start = 1'b0;
      red_x = coef_rda_ff;
      mul_start = 1'b0;
      mul_a = x_ff;
      mul_b = direction_ff ? root_inv_ff : root_ff;
      case (state_ff)
         ST_IDLE: begin
            red_start = req_ch.valid;
            red_x = req_ch.coefficient & CMASK;
         end
         ST_LD_RED: begin
            coef_we = red_done;
            coef_waddr = load_count_ff[AW-1:0];
            coef_wdata = red_res;
         end
         ST_RR_GO: red_start = 1'b1;
         ST_RR_RUN: begin
            coef_we = red_done;
            coef_wdata = red_res;
         end
         ST_PW_WR: mul_start = (idx_ff != last_idx);
         ST_TW_GO: begin
            mul_start = 1'b1;
            mul_a = coef_rda_ff;
            mul_b = power_rd_ff;
         end
         ST_TW_RUN: coef_we = mul_done;
         ST_BF_GO: begin
            mul_start = 1'b1;
            if (direction_ff) begin
               mul_a = coef_rdb_ff;
               mul_b = power_rd_ff;
            end else begin
               mul_a = sub_mod(coef_rda_ff, coef_rdb_ff, q);
               mul_b = power_rd_ff;
               coef_we = 1'b1;
               coef_waddr = k_lo;
               coef_wdata = add_mod(coef_rda_ff, coef_rdb_ff, q);
            end
         end
         ST_BF_RUN: begin
            coef_we = mul_done;
            if (direction_ff) begin
               coef_waddr = k_lo;
               coef_wdata = add_mod(u_ff, mul_res, q);
            end else begin
               coef_waddr = k_hi;
            end
         end
         ST_BF_WR2: begin
            coef_we = 1'b1;
            coef_waddr = k_hi;
            coef_wdata = sub_mod(u_ff, res_ff, q);
         end
         ST_SC_GO: begin
            mul_start = 1'b1;
            mul_a = power_rd_ff;
            mul_b = size_inv_ff;
         end
         ST_SC_MUL1: begin
            mul_start = mul_done;
            mul_a = v_ff;
            mul_b = mul_res;
         end
         ST_SC_MUL2: coef_we = mul_done;
         default: ;
      endcase
   end

   // coefficient store and power table, registered reads
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_rda_ff <= coef_mem[coef_raddr_a];
      coef_rdb_ff <= coef_mem[coef_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (power_we) begin
         power_mem[idx_ff] <= x_ff;
      end
      power_rd_ff <= power_mem[power_raddr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         load_count_ff <= '0;
         idx_ff <= '0;
         stage_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff <= 1'b0;
         modulus_ff <= word_type'(3);
         root_ff <= word_type'(1);
         root_inv_ff <= word_type'(1);
         size_inv_ff <= word_type'(1);
         direction_ff <= 1'b0;
         log_size_ff <= 3'd6;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MODULUS: modulus_ff <= csr_write_data;
               CSR_ROOT: root_ff <= csr_write_data;
               CSR_ROOT_INVERSE: root_inv_ff <= csr_write_data;
               CSR_SIZE_INVERSE: size_inv_ff <= csr_write_data;
               CSR_DIRECTION: direction_ff <= csr_write_data[0];
               CSR_LOG_SIZE: begin
                  log_size_ff <= csr_write_data[2:0];
                  load_count_ff <= '0;
               end
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) state_ff <= ST_LD_RED;
            end
            ST_LD_RED: begin
               if (red_done) begin
                  if (load_count_ff[AW-1:0] == last_idx) begin
                     load_count_ff <= '0;
                     idx_ff <= '0;
                     state_ff <= ST_RR_RD;
                  end else begin
                     load_count_ff <= load_count_ff + 1'b1;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            // reduce the whole store against the modulus now in force
            ST_RR_RD: state_ff <= ST_RR_GO;
            ST_RR_GO: state_ff <= ST_RR_RUN;
            ST_RR_RUN: begin
               if (red_done) begin
                  if (idx_ff == last_idx) begin
                     idx_ff <= '0;
                     x_ff <= word_type'(1);
                     state_ff <= (log_eff == '0) ? ST_OUT_RD : ST_PW_WR;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_RR_RD;
                  end
               end
            end
            // power table: x = base^i
            ST_PW_WR: begin
               if (idx_ff == last_idx) begin
                  idx_ff <= '0;
                  if (direction_ff) begin
                     stage_ff <= '0;
                     state_ff <= ST_BF_RD;
                  end else begin
                     state_ff <= ST_TW_RD;
                  end
               end else begin
                  state_ff <= ST_PW_MUL;
               end
            end
            ST_PW_MUL: begin
               if (mul_done) begin
                  x_ff <= mul_res;
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= ST_PW_WR;
               end
            end
            // forward pre-twist
            ST_TW_RD: state_ff <= ST_TW_GO;
            ST_TW_GO: state_ff <= ST_TW_RUN;
            ST_TW_RUN: begin
               if (mul_done) begin
                  if (idx_ff == last_idx) begin
                     idx_ff <= '0;
                     stage_ff <= log_eff - 1'b1;
                     state_ff <= ST_BF_RD;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_TW_RD;
                  end
               end
            end
            // butterflies
            ST_BF_RD: state_ff <= ST_BF_GO;
            ST_BF_GO: begin
               u_ff <= coef_rda_ff;
               state_ff <= ST_BF_RUN;
            end
            ST_BF_RUN: begin
               if (mul_done) begin
                  res_ff <= mul_res;
                  if (direction_ff) begin
                     state_ff <= ST_BF_WR2;
                  end else if (idx_ff == half_last) begin
                     idx_ff <= '0;
                     if (stage_ff == '0) begin
                        state_ff <= ST_OUT_RD;
                     end else begin
                        stage_ff <= stage_ff - 1'b1;
                        state_ff <= ST_BF_RD;
                     end
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_BF_RD;
                  end
               end
            end
            ST_BF_WR2: begin
               if (idx_ff == half_last) begin
                  idx_ff <= '0;
                  if (stage_ff == log_eff - 1'b1) begin
                     state_ff <= ST_SC_RD;
                  end else begin
                     stage_ff <= stage_ff + 1'b1;
                     state_ff <= ST_BF_RD;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= ST_BF_RD;
               end
            end
            // inverse scaling by psi^-i * n^-1
            ST_SC_RD: state_ff <= ST_SC_GO;
            ST_SC_GO: begin
               v_ff <= coef_rda_ff;
               state_ff <= ST_SC_MUL1;
            end
            ST_SC_MUL1: begin
               if (mul_done) state_ff <= ST_SC_MUL2;
            end
            ST_SC_MUL2: begin
               if (mul_done) begin
                  if (idx_ff == last_idx) begin
                     idx_ff <= '0;
                     state_ff <= ST_OUT_RD;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_SC_RD;
                  end
               end
            end
            // drain results in array order
            ST_OUT_RD: state_ff <= ST_OUT_LD;
            ST_OUT_LD: begin
               rsp_value_ff <= coef_rda_ff;
               rsp_last_ff <= (idx_ff == last_idx);
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
               if (rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     idx_ff <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_OUT_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.value = rsp_value_ff;
   assign rsp_ch.last = rsp_last_ff;

endmodule
`default_nettype wire

>>> src/nne_mulmod.sv
`default_nettype none
module nne_mulmod
   import nne_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire word_type a,
   input  wire word_type b,
   input  wire word_type q,
   output logic          done,
   output word_type      result
);

   localparam int CW = $clog2(WORD_BITS);

   word_type r_ff, r_in;
   word_type a_ff;
   word_type b_ff;
   word_type q_ff;
   logic [CW-1:0] cnt_ff;
   logic busy_ff;
   logic done_ff;
   word_type dbl;

   // one multiplier bit per cycle: double, then add a when the bit is set
   always_comb begin
      dbl = add_mod(r_ff, r_ff, q_ff);
      r_in = b_ff[WORD_BITS-1] ? add_mod(dbl, a_ff, q_ff) : dbl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '1;
            r_ff <= '0;
            a_ff <= a;
            b_ff <= b;
            q_ff <= q;
         end else if (busy_ff) begin
            r_ff <= r_in;
            b_ff <= b_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign result = r_ff;

endmodule
`default_nettype wire

>>> src/nne_reduce.sv
`default_nettype none
module nne_reduce
   import nne_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire word_type x,
   input  wire word_type q,
   output logic          done,
   output word_type      result
);

   localparam int CW = $clog2(WORD_BITS);

   word_type r_ff;
   word_type x_ff;
   word_type q_ff;
   logic [WORD_BITS:0] trial;
   logic [CW-1:0] cnt_ff;
   logic busy_ff;
   logic done_ff;

   // restoring remainder: shift in one dividend bit, subtract q when it fits
   assign trial = {r_ff, x_ff[WORD_BITS-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '1;
            r_ff <= '0;
            x_ff <= x;
            q_ff <= q;
         end else if (busy_ff) begin
            if (trial >= {1'b0, q_ff}) begin
               r_ff <= WORD_BITS'(trial - {1'b0, q_ff});
            end else begin
               r_ff <= trial[WORD_BITS-1:0];
            end
            x_ff <= x_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign result = r_ff;

endmodule
`default_nettype wire

>>> verif/tb.sv
module tb;
   import nne_pkg::*;

   localparam int LIMIT = 8000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   word_type csr_write_data = '0;

   nne_req_if req_ch ();
   nne_rsp_if rsp_ch ();

   negacyclic_ntt_engine i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #1 clock = ~clock;

   // predictor of the transform and queue of pending output values
   class ntt_scoreboard;
      word_type modulus_q = 64'd3, psi = 64'd1, psi_inv = 64'd1, n_inv = 64'd1;
      logic inverse_mode = 1'b0;
      logic [2:0] log_n = 3'd6;
      word_type store [64];
      word_type powers [64];
      int unsigned loaded = 0;
      word_type pending_value [$];
      logic pending_last [$];
      int errors = 0;
      int transforms = 0;
      int checked = 0;

      function word_type addm(word_type u, word_type v, word_type q);
         return (u >= q - v) ? (u - (q - v)) : (u + v);
      endfunction

      function word_type subm(word_type u, word_type v, word_type q);
         return (u < v) ? (q - (v - u)) : (u - v);
      endfunction

      function word_type mulm(word_type a, word_type b, word_type q);
         logic [127:0] p;
         p = {64'd0, a % q} * {64'd0, b % q};
         return word_type'(p % {64'd0, q});
      endfunction

      function void note_csr(csr_index_type idx, word_type data);
         case (idx)
            CSR_MODULUS: modulus_q = data;
            CSR_ROOT: psi = data;
            CSR_ROOT_INVERSE: psi_inv = data;
            CSR_SIZE_INVERSE: n_inv = data;
            CSR_DIRECTION: inverse_mode = data[0];
            CSR_LOG_SIZE: begin
               log_n = data[2:0];
               loaded = 0;
            end
            default: ;
         endcase
      endfunction

      function int unsigned points();
         return (log_n > 6) ? 64 : (1 << log_n);
      endfunction

      function void note_coefficient(word_type c);
         word_type q, x, w, u, v, f;
         int unsigned n, span, groups, k;
         q = (modulus_q < 2) ? 64'd2 : modulus_q;
         n = points();
         if (loaded >= n) loaded = 0;
         store[loaded] = c % q;
         loaded++;
         if (loaded < n) return;
         loaded = 0;
         transforms++;
         for (int i = 0; i < n; i++) store[i] = store[i] % q;
         if (n > 1) begin
            x = 64'd1;
            for (int i = 0; i < n; i++) begin
               powers[i] = x;
               x = mulm(x, inverse_mode ? psi_inv : psi, q);
            end
            if (!inverse_mode) begin
               for (int i = 0; i < n; i++) store[i] = mulm(store[i], powers[i], q);
               for (span = n >> 1; span >= 1; span >>= 1) begin
                  groups = n / (2 * span);
                  for (int j = 0; j < span; j++) begin
                     w = powers[(2 * j * groups) & 63];
                     for (int g = 0; g < groups; g++) begin
                        k = g * 2 * span + j;
                        u = store[k];
                        v = store[k + span];
                        store[k] = addm(u, v, q);
                        store[k + span] = mulm(subm(u, v, q), w, q);
                     end
                  end
               end
            end else begin
               for (span = 1; span < n; span <<= 1) begin
                  groups = n / (2 * span);
                  for (int j = 0; j < span; j++) begin
                     w = powers[(2 * j * groups) & 63];
                     for (int g = 0; g < groups; g++) begin
                        k = g * 2 * span + j;
                        u = store[k];
                        v = mulm(store[k + span], w, q);
                        store[k] = addm(u, v, q);
                        store[k + span] = subm(u, v, q);
                     end
                  end
               end
               for (int i = 0; i < n; i++) begin
                  f = mulm(powers[i], n_inv, q);
                  store[i] = mulm(store[i], f, q);
               end
            end
         end
         for (int i = 0; i < n; i++) begin
            pending_value.push_back(store[i]);
            pending_last.push_back(i + 1 == n);
         end
      endfunction

      function void check_value(word_type value, logic last);
         word_type ev;
         logic el;
         checked++;
         if (pending_value.size() == 0) begin
            $error("unexpected output item value=%h last=%b", value, last);
            errors++;
            return;
         end
         ev = pending_value.pop_front();
         el = pending_last.pop_front();
         if (value !== ev) begin
            $error("value: expected %h actual %h", ev, value);
            errors++;
         end
         if (last !== el) begin
            $error("last: expected %b actual %b", el, last);
            errors++;
         end
      endfunction
   endclass

   ntt_scoreboard board = new();
   int send_idle = 0;
   int recv_idle = 0;
   int unsigned cycles = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.coefficient = '0;
      rsp_ch.ready = 1'b0;
   end

   // random receiver stall, check each accepted item
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout");
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_value(rsp_ch.value, rsp_ch.last);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
   end

   // wait until no item is in flight, then write one register
   task automatic write_csr(csr_index_type idx, word_type data);
      do @(posedge clock);
      while (board.pending_value.size() != 0 || !req_ch.ready);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      board.note_csr(idx, data);
      csr_write_enable <= 1'b0;
   endtask

   // hold valid until accepted, with random gaps before
   task automatic send_coefficient(word_type c);
      do @(posedge clock);
      while ($urandom_range(99) < send_idle);
      req_ch.valid <= 1'b1;
      req_ch.coefficient <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_coefficient(c);
      req_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      while (board.pending_value.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic word_type rand_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic word_type rand_coefficient();
      case ($urandom_range(3))
         0: return 64'hFFFF_FFFF_FFFF_FFFF;
         1: return word_type'($urandom_range(7));
         default: return rand_word();
      endcase
   endfunction

   // set up one transform setting: a modulus, mostly prime, and roots
   task automatic setup(logic inv, logic [2:0] logn);
      word_type q, r, ri, ni;
      case ($urandom_range(3))
         0: begin q = 64'd257; r = 64'd3; end
         1: begin q = 64'd12289; r = 64'd11; end
         2: begin q = 64'hFFFF_FFFF_0000_0001; r = 64'd7; end
         default: begin q = rand_word() | 64'h1; r = rand_word(); end
      endcase
      ri = rand_word();
      ni = $urandom_range(1) ? rand_word() : 64'd1;
      write_csr(CSR_MODULUS, q);
      write_csr(CSR_ROOT, r);
      write_csr(CSR_ROOT_INVERSE, ri);
      write_csr(CSR_SIZE_INVERSE, ni);
      write_csr(CSR_DIRECTION, {63'd0, inv});
      write_csr(CSR_LOG_SIZE, {61'd0, logn});
   endtask

   task automatic run_block(int unsigned n);
      for (int i = 0; i < n; i++) send_coefficient(rand_coefficient());
   endtask

   int unsigned sent;
   logic [2:0] logn;

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, size one, tiny modulus, oversized log_size
      send_idle = 0; recv_idle = 0;
      write_csr(CSR_LOG_SIZE, 64'd1);
      send_coefficient(64'hFFFF_FFFF_FFFF_FFFF);
      send_coefficient(64'd0);
      drain();
      write_csr(CSR_LOG_SIZE, 64'd0);
      send_coefficient(64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_MODULUS, 64'd0);
      send_coefficient(64'd5);
      write_csr(CSR_MODULUS, 64'd1);
      send_coefficient(64'h8000_0000_0000_0001);
      drain();
      write_csr(CSR_MODULUS, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_ROOT, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_ROOT_INVERSE, 64'hFFFF_FFFF_FFFF_FFFE);
      write_csr(CSR_SIZE_INVERSE, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_DIRECTION, 64'd1);
      write_csr(CSR_LOG_SIZE, 64'd2);
      run_block(4);
      drain();
      // log_size write mid-load restarts the load; modulus change mid-load
      write_csr(CSR_DIRECTION, 64'd0);
      write_csr(CSR_LOG_SIZE, 64'd3);
      run_block(3);
      drain();
      write_csr(CSR_LOG_SIZE, 64'd7);
      write_csr(CSR_LOG_SIZE, 64'd2);
      send_coefficient(64'd1000);
      send_coefficient(64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_MODULUS, 64'd17);
      run_block(2);
      drain();

      // random phases with three idling profiles
      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 26 : (phase == 1) ? 72 : 0;
         recv_idle = (phase == 0) ? 72 : (phase == 1) ? 26 : 0;
         while (sent < (phase + 1) * 134) begin
            // mostly small sizes, an occasional full-length transform
            logn = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 3));
            setup(1'($urandom_range(1)), logn);
            run_block(board.points());
            sent += board.points();
            drain();
         end
      end

      drain();
      $display("covered %0d transforms, %0d output items checked",
               board.transforms, board.checked);
      $display("forward and inverse, sizes 1..64, random and edge moduli");
      if (board.errors == 0 && board.pending_value.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
